/* src/cbsv_pkg.sv */
package cbsv_pkg;

  localparam int MAX_NESTING_DEF = 32;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_RESERVED  = 4'd1;
  localparam logic [3:0] ST_TRUNC_ARG = 4'd2;
  localparam logic [3:0] ST_TRUNC_STR = 4'd3;
  localparam logic [3:0] ST_TRUNC_CNT = 4'd4;
  localparam logic [3:0] ST_MAP_OVF   = 4'd5;
  localparam logic [3:0] ST_NESTING   = 4'd6;
  localparam logic [3:0] ST_TAG       = 4'd7;
  localparam logic [3:0] ST_TRAILING  = 4'd8;

  localparam logic [2:0] MAJ_BSTR  = 3'd2;
  localparam logic [2:0] MAJ_TSTR  = 3'd3;
  localparam logic [2:0] MAJ_ARRAY = 3'd4;
  localparam logic [2:0] MAJ_MAP   = 3'd5;
  localparam logic [2:0] MAJ_TAG   = 3'd6;

  localparam logic [4:0] ADD_ARG_BYTES = 5'd24;
  localparam logic [4:0] ADD_RESERVED  = 5'd28;

  typedef enum logic [2:0] {
    PH_INITIAL  = 3'b001,
    PH_ARGUMENT = 3'b010,
    PH_STRING   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] major;
    logic [4:0] add;
  } item_t;

endpackage

/* src/cbor_structure_validator_top.sv */
// The final byte passes the byte queue and is consumed in the execute state; the status
// is then registered in the finish state once the output is free. Each finished container
// count dropped costs a stack memory read and a refill of the top-of-stack register, and
// each payload end a finish step; apart from these and output stalls, one byte per cycle.
// Reset (rst_n low, synchronous) empties the byte queue and output and sets depth one.
module cbor_structure_validator_top #(
  parameter int MAX_NESTING = cbsv_pkg::MAX_NESTING_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_payload,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_status
);

  logic            q_valid;
  cbsv_pkg::item_t q_item;
  logic            q_deq;

  cbsv_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_payload (in_end_of_payload),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_deq             (q_deq)
  );

  cbsv_back #(
    .MAX_NESTING (MAX_NESTING)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_deq      (q_deq),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status)
  );

endmodule

/* src/cbsv_front.sv */
module cbsv_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_end_of_payload,
  output logic            q_valid,
  output cbsv_pkg::item_t q_item,
  input  logic            q_deq
);

  cbsv_pkg::item_t                  ent_r [cbsv_pkg::QDEPTH];
  logic [cbsv_pkg::QAW-1:0]         wr_ptr_r;
  logic [cbsv_pkg::QAW-1:0]         rd_ptr_r;
  logic [cbsv_pkg::QCW-1:0]         cnt_r;
  logic                             enq;
  logic                             deq;
  cbsv_pkg::item_t                  cls;

  assign in_ready = (cnt_r != cbsv_pkg::QCW'(cbsv_pkg::QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = ent_r[rd_ptr_r];
  assign enq      = in_valid && in_ready;
  assign deq      = q_deq && q_valid;

  always_comb begin
    cls.data  = in_data_byte;
    cls.last  = in_end_of_payload;
    cls.major = in_data_byte[7:5];
    cls.add   = in_data_byte[4:0];
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (deq) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({enq, deq})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* src/cbsv_back.sv */
module cbsv_back #(
  parameter int MAX_NESTING = cbsv_pkg::MAX_NESTING_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  cbsv_pkg::item_t q_item,
  output logic            q_deq,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      out_status
);

  localparam int DW = $clog2(MAX_NESTING + 2);
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  typedef enum logic [3:0] {
    S_EXEC  = 4'b0001,
    S_FILL  = 4'b0010,
    S_FIN   = 4'b0100,
    S_FFILL = 4'b1000
  } state_t;

  logic [63:0] mem [MAX_NESTING];
  logic [63:0] rd_r;

  state_t           state_r, state_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  cbsv_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]       major_r, major_nxt;
  logic [3:0]       arg_left_r, arg_left_nxt;
  logic [63:0]      arg_val_r, arg_val_nxt;
  logic [63:0]      str_left_r, str_left_nxt;
  logic [3:0]       err_r, err_nxt;
  logic [63:0]      top_r, top_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       out_status_r, out_status_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [63:0]      mem_wd;
  logic [AW-1:0]    mem_ra;

  logic [63:0]      top_v;
  logic             do_cmp;
  logic [2:0]       cmaj;
  logic [63:0]      carg;
  logic [63:0]      children;
  logic [3:0]       fin_status;
  logic             emit;
  logic             out_free;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    phase_nxt      = phase_r;
    major_nxt      = major_r;
    arg_left_nxt   = arg_left_r;
    arg_val_nxt    = arg_val_r;
    str_left_nxt   = str_left_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    q_deq          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = AW'(depth_r - DW'(1));
    mem_ra         = AW'(depth_r - DW'(2));
    top_v          = top_r;
    do_cmp         = 1'b0;
    cmaj           = major_r;
    carg           = arg_val_r;
    children       = '0;
    fin_status     = err_r;
    emit           = 1'b0;
    mem_wd         = top_r;

    case (state_r)
      S_EXEC: begin
        if (q_valid) begin
          if (err_r != cbsv_pkg::ST_OK) begin
            q_deq = 1'b1;
          end else if (phase_r == cbsv_pkg::PH_ARGUMENT) begin
            q_deq        = 1'b1;
            arg_val_nxt  = {arg_val_r[55:0], q_item.data};
            arg_left_nxt = arg_left_r - 4'd1;
            if (arg_left_nxt == 4'd0) begin
              do_cmp = 1'b1;
              carg   = arg_val_nxt;
            end
          end else if (phase_r == cbsv_pkg::PH_STRING) begin
            q_deq        = 1'b1;
            str_left_nxt = str_left_r - 64'd1;
            if (str_left_nxt == 64'd0) begin
              phase_nxt = cbsv_pkg::PH_INITIAL;
            end
          end else if (depth_r != '0 && top_r == 64'd0) begin
            depth_nxt = depth_r - DW'(1);
            state_nxt = S_FILL;
          end else begin
            q_deq = 1'b1;
            if (depth_r == '0) begin
              err_nxt = cbsv_pkg::ST_TRAILING;
            end else begin
              top_v     = top_r - 64'd1;
              top_nxt   = top_v;
              major_nxt = q_item.major;
              cmaj      = q_item.major;
              if (q_item.add < cbsv_pkg::ADD_ARG_BYTES) begin
                do_cmp = 1'b1;
                carg   = {59'd0, q_item.add};
              end else if (q_item.add < cbsv_pkg::ADD_RESERVED) begin
                arg_left_nxt = 4'd1 << q_item.add[1:0];
                arg_val_nxt  = '0;
                phase_nxt    = cbsv_pkg::PH_ARGUMENT;
              end else begin
                err_nxt = cbsv_pkg::ST_RESERVED;
              end
            end
          end
          if (q_deq && q_item.last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FILL: begin
        top_nxt   = rd_r;
        state_nxt = S_EXEC;
      end
      S_FIN: begin
        if (err_r != cbsv_pkg::ST_OK) begin
          emit = 1'b1;
        end else if (phase_r == cbsv_pkg::PH_ARGUMENT) begin
          fin_status = cbsv_pkg::ST_TRUNC_ARG;
          emit       = 1'b1;
        end else if (phase_r == cbsv_pkg::PH_STRING) begin
          fin_status = cbsv_pkg::ST_TRUNC_STR;
          emit       = 1'b1;
        end else if (depth_r != '0 && top_r == 64'd0) begin
          depth_nxt = depth_r - DW'(1);
          state_nxt = S_FFILL;
        end else if (depth_r != '0) begin
          fin_status = cbsv_pkg::ST_TRUNC_CNT;
          emit       = 1'b1;
        end else begin
          fin_status = cbsv_pkg::ST_OK;
          emit       = 1'b1;
        end
        if (emit && out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          state_nxt      = S_EXEC;
          depth_nxt      = DW'(1);
          top_nxt        = 64'd1;
          phase_nxt      = cbsv_pkg::PH_INITIAL;
          major_nxt      = '0;
          arg_left_nxt   = '0;
          arg_val_nxt    = '0;
          str_left_nxt   = '0;
          err_nxt        = cbsv_pkg::ST_OK;
        end
      end
      S_FFILL: begin
        top_nxt   = rd_r;
        state_nxt = S_FIN;
      end
      default: begin
        state_nxt = S_EXEC;
      end
    endcase

    if (do_cmp) begin
      phase_nxt = cbsv_pkg::PH_INITIAL;
      if (cmaj == cbsv_pkg::MAJ_BSTR || cmaj == cbsv_pkg::MAJ_TSTR) begin
        if (carg != 64'd0) begin
          str_left_nxt = carg;
          phase_nxt    = cbsv_pkg::PH_STRING;
        end
      end else if (cmaj == cbsv_pkg::MAJ_ARRAY || cmaj == cbsv_pkg::MAJ_MAP) begin
        if (cmaj == cbsv_pkg::MAJ_MAP && carg[63]) begin
          err_nxt = cbsv_pkg::ST_MAP_OVF;
        end else begin
          children = (cmaj == cbsv_pkg::MAJ_MAP) ? {carg[62:0], 1'b0} : carg;
          if (children != 64'd0) begin
            if (depth_r > DW'(MAX_NESTING)) begin
              err_nxt = cbsv_pkg::ST_NESTING;
            end else begin
              mem_we    = 1'b1;
              mem_wd    = top_v;
              top_nxt   = children;
              depth_nxt = depth_r + DW'(1);
            end
          end
        end
      end else if (cmaj == cbsv_pkg::MAJ_TAG) begin
        err_nxt = cbsv_pkg::ST_TAG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      depth_r     <= DW'(1);
      phase_r     <= cbsv_pkg::PH_INITIAL;
      major_r     <= '0;
      arg_left_r  <= '0;
      arg_val_r   <= '0;
      str_left_r  <= '0;
      err_r       <= cbsv_pkg::ST_OK;
      top_r       <= 64'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      phase_r     <= phase_nxt;
      major_r     <= major_nxt;
      arg_left_r  <= arg_left_nxt;
      arg_val_r   <= arg_val_nxt;
      str_left_r  <= str_left_nxt;
      err_r       <= err_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

endmodule

/* tb/tb_cbor_structure_validator_top.sv */
module tb_cbor_structure_validator_top;

  localparam int NEST        = cbsv_pkg::MAX_NESTING_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int BYTE_TARGET = 1950;
  localparam int SETTLE      = 3 + 2 * (NEST + 1) + 8;

  localparam logic [2:0] MAJ_UINT   = 3'd0;
  localparam logic [2:0] MAJ_NINT   = 3'd1;
  localparam logic [2:0] MAJ_SIMPLE = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_payload = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [3:0] out_status;

  bit         idle_on = 1'b1;
  int         cycle_count;
  int         npay;
  logic [7:0] pay[$];

  cbor_structure_validator_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_payload (in_end_of_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status)
  );

  class status_tracker;
    logic [63:0]      counts [0:NEST];
    int               depth;
    cbsv_pkg::phase_t phase;
    logic [2:0]       major;
    int               arg_left;
    logic [63:0]      arg;
    logic [63:0]      str_left;
    logic [3:0]       err;
    logic [3:0]       pending_status[$];
    int               errors;
    int               payloads;
    int               bytes;
    int               clean;

    function new();
      restart();
    endfunction

    function void restart();
      foreach (counts[i]) counts[i] = '0;
      counts[0] = 64'd1;
      depth = 1;
      phase = cbsv_pkg::PH_INITIAL;
      major = '0;
      arg_left = 0;
      arg = '0;
      str_left = '0;
      err = cbsv_pkg::ST_OK;
    endfunction

    function void drop_done();
      while (depth > 0 && depth <= NEST + 1 && counts[depth-1] == 0) depth--;
    endfunction

    function void close_head(logic [2:0] maj, logic [63:0] a);
      logic [63:0] kids;
      phase = cbsv_pkg::PH_INITIAL;
      if (maj == cbsv_pkg::MAJ_BSTR || maj == cbsv_pkg::MAJ_TSTR) begin
        if (a != 0) begin
          str_left = a;
          phase = cbsv_pkg::PH_STRING;
        end
      end else if (maj == cbsv_pkg::MAJ_ARRAY || maj == cbsv_pkg::MAJ_MAP) begin
        if (maj == cbsv_pkg::MAJ_MAP && a[63]) begin
          err = cbsv_pkg::ST_MAP_OVF;
          return;
        end
        kids = (maj == cbsv_pkg::MAJ_MAP) ? a << 1 : a;
        if (kids != 0) begin
          if (depth > NEST) begin
            err = cbsv_pkg::ST_NESTING;
            return;
          end
          counts[depth] = kids;
          depth++;
        end
      end else if (maj == cbsv_pkg::MAJ_TAG) begin
        err = cbsv_pkg::ST_TAG;
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      case (phase)
        cbsv_pkg::PH_ARGUMENT: begin
          arg = {arg[55:0], b};
          if (arg_left > 0) arg_left--;
          if (arg_left == 0) close_head(major, arg);
        end
        cbsv_pkg::PH_STRING: begin
          if (str_left != 0) str_left--;
          if (str_left == 0) phase = cbsv_pkg::PH_INITIAL;
        end
        default: begin
          drop_done();
          if (depth == 0 || depth > NEST + 1) begin
            err = cbsv_pkg::ST_TRAILING;
            return;
          end
          counts[depth-1]--;
          major = b[7:5];
          if (b[4:0] < cbsv_pkg::ADD_ARG_BYTES) begin
            close_head(major, 64'(b[4:0]));
          end else if (b[4:0] < cbsv_pkg::ADD_RESERVED) begin
            arg_left = 1 << (b[4:0] - cbsv_pkg::ADD_ARG_BYTES);
            arg = '0;
            phase = cbsv_pkg::PH_ARGUMENT;
          end else begin
            err = cbsv_pkg::ST_RESERVED;
          end
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [3:0] s;
      bytes++;
      if (err == cbsv_pkg::ST_OK) parse_byte(b);
      if (!last) return;
      s = err;
      if (s == cbsv_pkg::ST_OK) begin
        if (phase == cbsv_pkg::PH_ARGUMENT) begin
          s = cbsv_pkg::ST_TRUNC_ARG;
        end else if (phase == cbsv_pkg::PH_STRING) begin
          s = cbsv_pkg::ST_TRUNC_STR;
        end else begin
          drop_done();
          if (depth != 0) s = cbsv_pkg::ST_TRUNC_CNT;
        end
      end
      pending_status.insert(pending_status.size(), s);
      payloads++;
      if (s == cbsv_pkg::ST_OK) clean++;
      restart();
    endfunction

    task report(string msg);
      $display("%0t %s", $time, msg);
      errors++;
    endtask

    task check_status(logic [3:0] s);
      logic [3:0] want;
      if (pending_status.size() == 0) begin
        report($sformatf("status %0d arrived with no payload pending", s));
      end else begin
        want = pending_status.pop_front();
        if (s !== want) report($sformatf("status %0d, want %0d", s, want));
      end
    endtask
  endclass

  status_tracker tracker = new();

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("cbor_structure_validator_top: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_status(out_status);
    out_ready <= !(idle_on && $urandom_range(99) < 8);
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_payload <= last;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b, last);
  endtask

  task automatic send_payload();
    foreach (pay[i]) push_byte(pay[i], i == pay.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_status.size() != 0);
  endtask

  function automatic void add_byte(logic [7:0] b);
    pay.insert(pay.size(), b);
  endfunction

  function automatic void put_head(logic [2:0] maj, logic [63:0] val);
    int lo;
    int w;
    lo = (val[63:32] != 0) ? 4 : (val[31:16] != 0) ? 3 : (val[15:8] != 0) ? 2 :
         (val > 23) ? 1 : 0;
    w = ($urandom_range(3) != 0) ? lo : $urandom_range(4, lo);
    if (w == 0) begin
      add_byte({maj, val[4:0]});
    end else begin
      add_byte({maj, 5'(cbsv_pkg::ADD_ARG_BYTES + w - 1)});
      for (int i = (1 << (w - 1)) - 1; i >= 0; i--) add_byte(val[8*i +: 8]);
    end
  endfunction

  function automatic void gen_item(int lvl);
    int          kind;
    int          n;
    logic [63:0] v;
    kind = (lvl >= 4) ? $urandom_range(4) : $urandom_range(9);
    v = {$urandom, $urandom} >> $urandom_range(63);
    case (kind)
      0: put_head(MAJ_UINT, v);
      1: put_head(MAJ_NINT, v);
      2: put_head(MAJ_SIMPLE, v);
      3, 4: begin
        n = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
        put_head((kind == 3) ? cbsv_pkg::MAJ_BSTR : cbsv_pkg::MAJ_TSTR, 64'(n));
        repeat (n) add_byte(8'($urandom));
      end
      5, 6, 7: begin
        n = $urandom_range(3);
        put_head(cbsv_pkg::MAJ_ARRAY, 64'(n));
        repeat (n) gen_item(lvl + 1);
      end
      default: begin
        n = $urandom_range(2);
        put_head(cbsv_pkg::MAJ_MAP, 64'(n));
        repeat (2 * n) gen_item(lvl + 1);
      end
    endcase
  endfunction

  function automatic void build_random_payload();
    int          pick;
    int          n;
    logic [63:0] v;
    pay.delete();
    pick = $urandom_range(99);
    if (pick < 65) begin
      gen_item(0);
    end else if (pick < 73) begin
      gen_item(0);
      if (pay.size() > 1) begin
        n = $urandom_range(pay.size() - 1, 1);
        pay = pay[0:n-1];
      end
    end else if (pick < 78) begin
      gen_item(0);
      repeat ($urandom_range(3, 1)) add_byte(8'($urandom));
    end else if (pick < 83) begin
      gen_item(0);
      pay[$urandom_range(pay.size() - 1)] = 8'($urandom);
    end else if (pick < 87) begin
      gen_item(0);
      pay.insert($urandom_range(pay.size() - 1),
                 {3'($urandom), 5'($urandom_range(31, cbsv_pkg::ADD_RESERVED))});
    end else if (pick < 90) begin
      put_head(cbsv_pkg::MAJ_TAG, {$urandom, $urandom} >> $urandom_range(63));
      gen_item(0);
    end else if (pick < 93) begin
      add_byte({($urandom_range(3) == 0) ? cbsv_pkg::MAJ_ARRAY : cbsv_pkg::MAJ_MAP,
                cbsv_pkg::ADD_ARG_BYTES + 5'd3});
      case ($urandom_range(2))
        0: v = {1'b1, 31'($urandom), 32'($urandom)};
        1: v = 64'h7fff_ffff_ffff_ffff;
        default: v = {$urandom, $urandom};
      endcase
      for (int i = 7; i >= 0; i--) add_byte(v[8*i +: 8]);
      repeat ($urandom_range(2)) gen_item(2);
    end else if (pick < 96) begin
      n = $urandom_range(35, 29);
      repeat (n) add_byte(($urandom_range(19) == 0) ? {cbsv_pkg::MAJ_MAP, 5'd1}
                                                    : {cbsv_pkg::MAJ_ARRAY, 5'd1});
      gen_item(4);
    end else begin
      repeat ($urandom_range(8, 1)) add_byte(8'($urandom));
    end
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pay = '{8'h00};                  send_payload();
    pay = '{8'hff};                  send_payload();
    pay = '{8'h1c};                  send_payload();
    pay = '{8'h19, 8'h01};           send_payload();
    pay = '{8'h62, 8'h61};           send_payload();
    pay = '{8'h82, 8'h01};           send_payload();
    pay = '{8'hc1, 8'h00};           send_payload();
    pay = '{8'h01, 8'h02};           send_payload();
    pay = '{8'ha0};                  send_payload();
    pay = '{8'hf8, 8'hff};           send_payload();
    pay = '{8'h81, 8'h81, 8'h80};    send_payload();
    pay = '{8'h1c, 8'h00};           send_payload();
    wait_drained();

    npay = 0;
    while (tracker.bytes < BYTE_TARGET) begin
      idle_on = !(npay >= 60 && npay < 110);
      build_random_payload();
      send_payload();
      npay++;
      if (npay == 150) wait_drained();
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("run: %0d payloads over %0d bytes, %0d well formed, %0d rejected",
             tracker.payloads, tracker.bytes, tracker.clean,
             tracker.payloads - tracker.clean);
    $display("run: truncated, trailing, tagged, overflowing and over-nested payloads seen");
    if (tracker.errors == 0 && tracker.pending_status.size() == 0) begin
      $display("cbor_structure_validator_top: match");
    end else begin
      $display("cbor_structure_validator_top: mismatch");
    end
    $finish;
  end

endmodule
